// ===== src/mirs_pkg.sv =====
// ----------------------------------------------------------------------------
// Mesh index remap splitter package
// Shared widths, limits and the remap table entry layout.
// ----------------------------------------------------------------------------
package mirs_pkg;

    localparam int SRC_W   = 18;
    localparam int LOCAL_W = 16;
    localparam int CHUNK_W = 16;
    localparam int TOTAL_W = 19;
    localparam int COUNT_W = 17;
    localparam int CORNER_W = 2;

    localparam int MAX_SOURCE_VERTICES = 262144;
    localparam int TABLE_AW            = $clog2(MAX_SOURCE_VERTICES);
    localparam int CHUNK_VERTEX_LIMIT  = 65536;

    // Tag width of the table; each table clear moves to the next epoch
    localparam int EPOCH_W = 16;

    localparam logic [TOTAL_W-1:0]  PASS_LIMIT  = TOTAL_W'(CHUNK_VERTEX_LIMIT);
    localparam logic [COUNT_W-1:0]  SPLIT_LIMIT = COUNT_W'(CHUNK_VERTEX_LIMIT - 3);
    localparam logic [CHUNK_W-1:0]  CHUNK_MAX   = {CHUNK_W{1'b1}};
    localparam logic [EPOCH_W-1:0]  EPOCH_MAX   = {EPOCH_W{1'b1}};
    localparam logic [EPOCH_W-1:0]  EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [CORNER_W-1:0] CORNER_LAST = CORNER_W'(2);
    localparam logic [TABLE_AW-1:0] TABLE_LAST  = TABLE_AW'(MAX_SOURCE_VERTICES - 1);

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [LOCAL_W-1:0] local_idx;
    } remap_entry_t;

    localparam int ENTRY_W = $bits(remap_entry_t);

endpackage

// ===== src/mirs_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mirs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/mesh_index_remap_splitter.sv =====
// ----------------------------------------------------------------------------
// Mesh index remap splitter
// Re-indexes a triangle index stream into chunks of at most 65536 vertices.
// ----------------------------------------------------------------------------
// Usage:
//   Item channel (item_valid/item_stall) takes one source vertex index per
//   item; start_mesh marks the first index of a mesh and resets all state.
//   Result channel (result_valid/result_stall) returns one item per input:
//   the local index, the chunk number, chunk_start, fetch_vertex with the
//   source index to copy, and pass_through.
//   cfg_wr_en/cfg_wr_data write total_vertices; write it only while idle.
//   Flow: an accepted item passes the lookup stage, then the result register.
//   Throughput: one item per cycle when no sweep or result stall holds it,
//   set by the single read-modify-write of the remap table per item; a write
//   followed by a read of the same entry in the next item is forwarded.
//   Reset: a clearing pass sweeps all 262144 table entries, one per cycle,
//   before the first item is taken. Table clears use an epoch tag; a clear
//   that finds the epoch at its maximum (65535) wraps it, and the item that
//   caused the clear waits for another full table sweep.
//   Stall: when result_stall holds the result, the item in the lookup stage
//   holds too, and item_stall rises until the result drains.
// ----------------------------------------------------------------------------
module mesh_index_remap_splitter
    import mirs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration
    input  logic                cfg_wr_en,
    input  logic [TOTAL_W-1:0]  cfg_wr_data,
    // item channel
    input  logic                item_valid,
    output logic                item_stall,
    input  logic [SRC_W-1:0]    source_index,
    input  logic                start_mesh,
    // result channel
    output logic                result_valid,
    input  logic                result_stall,
    output logic [LOCAL_W-1:0]  local_index,
    output logic [CHUNK_W-1:0]  chunk_number,
    output logic                chunk_start,
    output logic                fetch_vertex,
    output logic [SRC_W-1:0]    fetch_source,
    output logic                pass_through
);

    typedef enum logic {
        ST_SWEEP,
        ST_RUN
    } state_t;

    // control state
    state_t                state_reg, state_next;
    logic [TABLE_AW-1:0]   sweep_addr_reg, sweep_addr_next;
    logic                  swept_reg, swept_next;
    logic [EPOCH_W-1:0]    epoch_reg, epoch_next;
    logic [TOTAL_W-1:0]    total_reg, total_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [CORNER_W-1:0]   corner_reg, corner_next;
    logic [CHUNK_W-1:0]    chunk_reg, chunk_next;
    logic                  open_reg, open_next;
    logic                  s2_valid_reg, s2_valid_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  fwd_hit_reg, fwd_hit_next;

    // payload
    logic [SRC_W-1:0]      s2_src_reg;
    logic                  s2_start_reg;
    remap_entry_t          fwd_data_reg;
    logic [LOCAL_W-1:0]    out_local_reg;
    logic [CHUNK_W-1:0]    out_chunk_reg;
    logic                  out_cstart_reg;
    logic                  out_fetch_reg;
    logic [SRC_W-1:0]      out_fsrc_reg;
    logic                  out_pt_reg;

    // lookup stage
    logic                  accept;
    logic                  s2_fire;
    logic                  out_free;
    logic                  need_sweep;
    logic                  pt_mode;
    logic                  open_eff;
    logic [CORNER_W-1:0]   corner_eff;
    logic [COUNT_W-1:0]    count_eff;
    logic [CHUNK_W-1:0]    chunk_eff;
    logic                  new_chunk;
    logic                  cstart;
    logic                  clear;
    logic [COUNT_W-1:0]    count_base;
    logic [EPOCH_W-1:0]    epoch_new;
    remap_entry_t          rd_entry;
    remap_entry_t          entry;
    remap_entry_t          wr_entry;
    logic [ENTRY_W-1:0]    ram_rd_data;
    logic                  hit;
    logic [LOCAL_W-1:0]    local_res;

    // table port
    logic                  ram_we;
    logic [TABLE_AW-1:0]   ram_wa;
    logic [ENTRY_W-1:0]    ram_wd;
    logic                  run_we;

    mirs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SOURCE_VERTICES)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wa),
        .wr_data (ram_wd),
        .rd_en   (accept),
        .rd_addr (source_index[TABLE_AW-1:0]),
        .rd_data (ram_rd_data)
    );

    // Evaluate the item in the lookup stage against the current state
    always_comb
    begin
        rd_entry   = remap_entry_t'(ram_rd_data);
        entry      = fwd_hit_reg ? fwd_data_reg : rd_entry;

        pt_mode    = (total_reg <= PASS_LIMIT);
        open_eff   = s2_start_reg ? 1'b0 : open_reg;
        corner_eff = s2_start_reg ? '0 : corner_reg;
        count_eff  = s2_start_reg ? '0 : count_reg;
        chunk_eff  = s2_start_reg ? '0 : chunk_reg;

        new_chunk  = !pt_mode && open_eff && (corner_eff == '0) && (count_eff > SPLIT_LIMIT);
        cstart     = !pt_mode && (!open_eff || new_chunk);
        clear      = s2_start_reg || cstart;
        count_base = cstart ? '0 : count_eff;

        // epoch wrap takes a full table sweep before the entry can be written
        epoch_new  = epoch_reg;
        if (clear)
        begin
            epoch_new = (epoch_reg == EPOCH_MAX) ? EPOCH_FIRST : epoch_reg + EPOCH_W'(1);
        end
        need_sweep = s2_valid_reg && clear && (epoch_reg == EPOCH_MAX) && !swept_reg;

        // a cleared table never hits
        hit        = !clear && (entry.epoch == epoch_reg);
        local_res  = hit ? entry.local_idx : count_base[LOCAL_W-1:0];

        wr_entry.epoch     = epoch_new;
        wr_entry.local_idx = count_base[LOCAL_W-1:0];

        out_free   = !out_valid_reg || !result_stall;
        s2_fire    = s2_valid_reg && (state_reg == ST_RUN) && !need_sweep && out_free;
        accept     = item_valid && !item_stall;
        run_we     = s2_fire && !pt_mode && !hit;

        if (state_reg == ST_SWEEP)
        begin
            ram_we = 1'b1;
            ram_wa = sweep_addr_reg;
            ram_wd = '0;
        end
        else
        begin
            ram_we = run_we;
            ram_wa = s2_src_reg[TABLE_AW-1:0];
            ram_wd = wr_entry;
        end
    end

    assign item_stall = !((state_reg == ST_RUN) && (!s2_valid_reg || s2_fire));

    // Next-state logic
    always_comb
    begin
        state_next      = state_reg;
        sweep_addr_next = sweep_addr_reg;
        swept_next      = swept_reg;
        epoch_next      = epoch_reg;
        total_next      = cfg_wr_en ? cfg_wr_data : total_reg;
        count_next      = count_reg;
        corner_next     = corner_reg;
        chunk_next      = chunk_reg;
        open_next       = open_reg;
        s2_valid_next   = accept || (s2_valid_reg && !s2_fire);
        out_valid_next  = s2_fire || (out_valid_reg && result_stall);
        // hold the forward decision for as long as the item waits in the stage
        fwd_hit_next    = accept ? (run_we && (source_index[TABLE_AW-1:0] == ram_wa))
                                 : fwd_hit_reg;

        unique case (state_reg)
            ST_SWEEP:
            begin
                sweep_addr_next = sweep_addr_reg + TABLE_AW'(1);
                if (sweep_addr_reg == TABLE_LAST)
                begin
                    state_next = ST_RUN;
                    epoch_next = EPOCH_FIRST;
                    swept_next = s2_valid_reg;
                end
            end
            ST_RUN:
            begin
                if (need_sweep)
                begin
                    state_next      = ST_SWEEP;
                    sweep_addr_next = '0;
                end
                else if (s2_fire)
                begin
                    swept_next = 1'b0;
                    epoch_next = epoch_new;
                    if (pt_mode)
                    begin
                        // hold state, drop it only on a new mesh
                        count_next  = count_eff;
                        corner_next = corner_eff;
                        chunk_next  = chunk_eff;
                        open_next   = open_eff;
                    end
                    else
                    begin
                        open_next   = 1'b1;
                        count_next  = hit ? count_base : count_base + COUNT_W'(1);
                        corner_next = (corner_eff >= CORNER_LAST) ? '0
                                                                  : corner_eff + CORNER_W'(1);
                        chunk_next  = chunk_eff;
                        if (new_chunk && (chunk_eff != CHUNK_MAX))
                        begin
                            chunk_next = chunk_eff + CHUNK_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_SWEEP;
            end
        endcase
    end

    // State, lookup stage and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            sweep_addr_reg <= '0;
            swept_reg      <= 1'b0;
            epoch_reg      <= EPOCH_FIRST;
            total_reg      <= '0;
            count_reg      <= '0;
            corner_reg     <= '0;
            chunk_reg      <= '0;
            open_reg       <= 1'b0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            fwd_hit_reg    <= 1'b0;
            s2_src_reg     <= '0;
            s2_start_reg   <= 1'b0;
            fwd_data_reg   <= '0;
            out_local_reg  <= '0;
            out_chunk_reg  <= '0;
            out_cstart_reg <= 1'b0;
            out_fetch_reg  <= 1'b0;
            out_fsrc_reg   <= '0;
            out_pt_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_addr_reg <= sweep_addr_next;
            swept_reg      <= swept_next;
            epoch_reg      <= epoch_next;
            total_reg      <= total_next;
            count_reg      <= count_next;
            corner_reg     <= corner_next;
            chunk_reg      <= chunk_next;
            open_reg       <= open_next;
            s2_valid_reg   <= s2_valid_next;
            out_valid_reg  <= out_valid_next;
            fwd_hit_reg    <= fwd_hit_next;
            if (accept)
            begin
                s2_src_reg   <= source_index;
                s2_start_reg <= start_mesh;
                fwd_data_reg <= wr_entry;
            end
            if (s2_fire)
            begin
                out_pt_reg <= pt_mode;
                if (pt_mode)
                begin
                    out_local_reg  <= s2_src_reg[LOCAL_W-1:0];
                    out_chunk_reg  <= '0;
                    out_cstart_reg <= 1'b0;
                    out_fetch_reg  <= 1'b0;
                    out_fsrc_reg   <= '0;
                end
                else
                begin
                    out_local_reg  <= local_res;
                    out_chunk_reg  <= chunk_next;
                    out_cstart_reg <= cstart;
                    out_fetch_reg  <= !hit;
                    out_fsrc_reg   <= hit ? '0 : s2_src_reg;
                end
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign local_index  = out_local_reg;
    assign chunk_number = out_chunk_reg;
    assign chunk_start  = out_cstart_reg;
    assign fetch_vertex = out_fetch_reg;
    assign fetch_source = out_fsrc_reg;
    assign pass_through = out_pt_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // The epoch never reaches the value left by a clearing pass
    a_epoch_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        epoch_reg != '0)
        else $error("remap epoch reached zero");

    // A new chunk always starts with a fetched vertex at local index zero
    a_chunk_start_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && chunk_start) |-> (fetch_vertex && (local_index == '0)))
        else $error("chunk start without fetch at local index zero");

    // Pass-through results carry no split information
    a_pass_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && pass_through) |-> (!fetch_vertex && !chunk_start
                                            && (chunk_number == '0)))
        else $error("pass-through result with split fields set");

    // No table write from the lookup stage while the sweep owns the port
    a_sweep_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> (!s2_fire && item_stall))
        else $error("item moved during table sweep");

endmodule
